// ----- rtl/dlp_pkg.sv -----
// Shared types and constants of the deduplicating newest-first item pool.
package dlp_pkg;

  localparam int unsigned OPC_W    = 3;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned S_DATA_W = 104;
  localparam int unsigned M_DATA_W = 104;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_FETCH  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_QUERY  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_NONE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DOWN,
    S_READ,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic                present;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  live_count;
    logic                last;
  } res_t;

endpackage

// ----- rtl/dlp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/dlp_ctrl.sv -----
// Sequencer of the item pool: slot scans, live bits, counters and the slot RAM.
module dlp_ctrl #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ID_BITS     = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dlp_pkg::OPC_W-1:0]      in_opcode_i,
  input  logic [dlp_pkg::ID_W-1:0]       in_id_i,
  input  logic [dlp_pkg::HANDLE_W-1:0]   in_handle_i,
  input  logic [dlp_pkg::COUNT_W-1:0]    in_count_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output dlp_pkg::res_t                  res_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned HW    = (HANDLE_BITS < dlp_pkg::HANDLE_W) ? HANDLE_BITS
                                                                    : dlp_pkg::HANDLE_W;
  localparam int unsigned RW    = ID_BITS + HW;

  dlp_pkg::state_e state_q, state_d;
  dlp_pkg::op_e    op_q, op_d;
  dlp_pkg::res_t   res_q, res_d;

  logic [ID_BITS-1:0]          id_q, id_d;
  logic [HW-1:0]               hdl_q, hdl_d;
  logic [dlp_pkg::COUNT_W-1:0] take_q, take_d;
  logic [CNT_W-1:0]            used_q, used_d;
  logic [CNT_W-1:0]            live_cnt_q, live_cnt_d;
  logic [CAPACITY-1:0]         live_q, live_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic [IDX_W-1:0]            pend_idx_q, pend_idx_d;
  logic                        pend_q, pend_d;
  logic                        issue_done_q, issue_done_d;

  logic                        ram_we, ram_re;
  logic [RW-1:0]               ram_rdata;
  logic [ID_BITS-1:0]          rd_id;
  logic [HW-1:0]               rd_hdl;
  logic [CNT_W-1:0]            used_m1;
  logic [dlp_pkg::COUNT_W-1:0] want, live_ext, take_first;
  logic                        hit, scan_end, pool_full, accept;

  assign rd_id  = ram_rdata[ID_BITS-1:0];
  assign rd_hdl = ram_rdata[RW-1:ID_BITS];

  assign used_m1   = used_q - CNT_W'(1);
  assign pool_full = (used_q == CNT_W'(CAPACITY));
  assign accept    = in_valid_i && in_ready_o;

  // A fetch of zero still takes one item; the number taken is known up front.
  assign want       = (in_count_i == '0) ? dlp_pkg::COUNT_W'(1) : in_count_i;
  assign live_ext   = dlp_pkg::COUNT_W'(live_cnt_q);
  assign take_first = (dlp_pkg::op_e'(in_opcode_i) == dlp_pkg::OP_POP) ?
                      dlp_pkg::COUNT_W'(1) : ((want < live_ext) ? want : live_ext);

  // Shared compare: the slot read in the previous cycle against the wanted id.
  assign hit      = pend_q && live_q[pend_idx_q] && (rd_id == id_q);
  assign scan_end = hit || (issue_done_q && !pend_q);

  assign ram_re = ((state_q == dlp_pkg::S_SCAN) && !issue_done_q) ||
                  ((state_q == dlp_pkg::S_DOWN) && live_q[idx_q]);
  assign ram_we = (state_q == dlp_pkg::S_SCAN) && scan_end && (op_q == dlp_pkg::OP_PUSH) &&
                  !hit && !pool_full;

  dlp_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (used_q[IDX_W-1:0]),
    .wdata_i ({hdl_q, id_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == dlp_pkg::S_IDLE);
  assign res_valid_o = (state_q == dlp_pkg::S_RESP);

  always_comb begin
    res_o            = res_q;
    res_o.live_count = dlp_pkg::COUNT_W'(live_cnt_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (dlp_pkg::op_e'(in_opcode_i))
            dlp_pkg::OP_PUSH, dlp_pkg::OP_REMOVE, dlp_pkg::OP_QUERY: begin
              state_d = dlp_pkg::S_SCAN;
            end
            dlp_pkg::OP_POP, dlp_pkg::OP_FETCH: begin
              state_d = (live_cnt_q == '0) ? dlp_pkg::S_RESP : dlp_pkg::S_DOWN;
            end
            dlp_pkg::OP_CLEAR: begin
              state_d = dlp_pkg::S_RESP;
            end
            default: begin
              state_d = dlp_pkg::S_IDLE;
            end
          endcase
        end
      end
      dlp_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = dlp_pkg::S_RESP;
        end
      end
      dlp_pkg::S_DOWN: begin
        if (live_q[idx_q]) begin
          state_d = dlp_pkg::S_READ;
        end
      end
      dlp_pkg::S_READ: begin
        state_d = dlp_pkg::S_RESP;
      end
      dlp_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = res_q.last ? dlp_pkg::S_IDLE : dlp_pkg::S_DOWN;
        end
      end
      default: begin
        state_d = dlp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d         = op_q;
    id_d         = id_q;
    hdl_d        = hdl_q;
    take_d       = take_q;
    used_d       = used_q;
    live_cnt_d   = live_cnt_q;
    live_d       = live_q;
    idx_d        = idx_q;
    pend_idx_d   = pend_idx_q;
    pend_d       = pend_q;
    issue_done_d = issue_done_q;
    res_d        = res_q;

    unique case (state_q)
      dlp_pkg::S_IDLE: begin
        if (accept) begin
          op_d         = dlp_pkg::op_e'(in_opcode_i);
          id_d         = in_id_i[ID_BITS-1:0];
          hdl_d        = in_handle_i[HW-1:0];
          idx_d        = '0;
          pend_d       = 1'b0;
          issue_done_d = (used_q == '0);
          res_d        = '0;
          res_d.last   = 1'b1;
          unique case (dlp_pkg::op_e'(in_opcode_i))
            dlp_pkg::OP_POP, dlp_pkg::OP_FETCH: begin
              if (live_cnt_q == '0) begin
                res_d.status = dlp_pkg::ST_NONE;
              end else begin
                take_d     = take_first;
                live_cnt_d = live_cnt_q - CNT_W'(take_first);
                idx_d      = used_m1[IDX_W-1:0];
              end
            end
            dlp_pkg::OP_CLEAR: begin
              live_d     = '0;
              used_d     = '0;
              live_cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      dlp_pkg::S_SCAN: begin
        pend_d     = !issue_done_q;
        pend_idx_d = idx_q;
        if (!issue_done_q) begin
          idx_d        = idx_q + IDX_W'(1);
          issue_done_d = (idx_q == used_m1[IDX_W-1:0]);
        end
        if (scan_end) begin
          res_d      = '0;
          res_d.last = 1'b1;
          unique case (op_q)
            dlp_pkg::OP_PUSH: begin
              if (hit) begin
                res_d.status = dlp_pkg::ST_DUP;
              end else if (pool_full) begin
                res_d.status = dlp_pkg::ST_FULL;
              end else begin
                live_d[used_q[IDX_W-1:0]] = 1'b1;
                used_d     = used_q + CNT_W'(1);
                live_cnt_d = live_cnt_q + CNT_W'(1);
              end
            end
            dlp_pkg::OP_REMOVE: begin
              if (hit) begin
                live_d[pend_idx_q] = 1'b0;
                live_cnt_d         = live_cnt_q - CNT_W'(1);
              end else begin
                res_d.status = dlp_pkg::ST_NONE;
              end
            end
            default: begin
              res_d.present = hit;
            end
          endcase
        end
      end
      dlp_pkg::S_DOWN: begin
        if (live_q[idx_q]) begin
          live_d[idx_q] = 1'b0;
        end else begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
      dlp_pkg::S_READ: begin
        res_d.status  = dlp_pkg::ST_DONE;
        res_d.present = 1'b0;
        res_d.id      = dlp_pkg::ID_W'(rd_id);
        res_d.handle  = dlp_pkg::HANDLE_W'(rd_hdl);
        res_d.last    = (take_q == dlp_pkg::COUNT_W'(1));
      end
      dlp_pkg::S_RESP: begin
        if (res_ready_i && !res_q.last) begin
          take_d = take_q - dlp_pkg::COUNT_W'(1);
          idx_d  = idx_q - IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dlp_pkg::S_IDLE;
      used_q       <= '0;
      live_cnt_q   <= '0;
      live_q       <= '0;
      take_q       <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      issue_done_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      live_cnt_q   <= live_cnt_d;
      live_q       <= live_d;
      take_q       <= take_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      issue_done_q <= issue_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    hdl_q      <= hdl_d;
    pend_idx_q <= pend_idx_d;
    res_q      <= res_d;
  end

endmodule

// ----- rtl/dlp_obuf.sv -----
// One-entry output register between the sequencer and the result stream.
module dlp_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dlp_pkg::res_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dlp_pkg::res_t out_data_o
);

  logic          full_q, full_d;
  dlp_pkg::res_t data_q;

  assign in_ready_o  = !full_q || out_ready_i;
  assign out_valid_o = full_q;
  assign out_data_o  = data_q;

  always_comb begin
    full_d = full_q;
    if (in_valid_i && in_ready_o) begin
      full_d = 1'b1;
    end else if (out_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

// ----- rtl/dedup_lifo_item_pool.sv -----
// Deduplicating newest-first item pool with stream ports; this is the top level.
//
// The block takes one operation at a time and drops s_axis_tready until the
// operation's last result has been handed to the output register. Push, remove
// and query read the slot RAM once per used slot, one slot a cycle (a match
// ends the scan early). Pop and fetch walk the live bits down from the newest
// used slot, one slot a cycle between results, and for each result read the
// RAM and then hand the result off. Clear, and a pop or fetch with nothing
// live, go straight to the result. An unknown opcode is taken and gives no
// result. Each hand-off waits for room in the output register, so stalls on
// the result stream hold up the block. A result may wait in the output
// register while the next operation is already being worked on.
module dedup_lifo_item_pool #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ID_BITS     = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // item_id [63:0], item_handle [95:64], fetch_count [102:96], zero pad [103]
  input  logic [dlp_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // opcode [2:0]
  input  logic [dlp_pkg::OPC_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // is_present [0], out_id [64:1], out_handle [96:65], live_count [103:97]
  output logic [dlp_pkg::M_DATA_W-1:0]    m_axis_tdata,
  // status [1:0]
  output logic [dlp_pkg::STAT_W-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast
);

  logic          res_valid, res_ready;
  dlp_pkg::res_t res, out_res;

  dlp_ctrl #(
    .CAPACITY    (CAPACITY),
    .ID_BITS     (ID_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .in_id_i     (s_axis_tdata[63:0]),
    .in_handle_i (s_axis_tdata[95:64]),
    .in_count_i  (s_axis_tdata[102:96]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  dlp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tuser         = out_res.status;
  assign m_axis_tlast         = out_res.last;
  assign m_axis_tdata[0]      = out_res.present;
  assign m_axis_tdata[64:1]   = out_res.id;
  assign m_axis_tdata[96:65]  = out_res.handle;
  assign m_axis_tdata[103:97] = out_res.live_count;

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[103:97] <= dlp_pkg::COUNT_W'(CAPACITY)))
    else $error("live count above capacity");

  a_present_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == dlp_pkg::ST_DONE))
    else $error("presence flag on a refused transaction");

  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == dlp_pkg::ST_NONE)) |->
      ((m_axis_tdata[96:1] == '0) && m_axis_tlast))
    else $error("not-found result carries an item");

  a_busy_while_fetching: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.last) |-> !s_axis_tready)
    else $error("input taken while a fetch still has results");
`endif

endmodule

// ----- bench/dedup_lifo_item_pool_test.sv -----
// Self-checking testbench for the deduplicating newest-first item pool.
module dedup_lifo_item_pool_test;

  localparam int unsigned POOL_SLOTS  = 64;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam logic [dlp_pkg::OPC_W-1:0] OPC_UNUSED_A = 3'd6;
  localparam logic [dlp_pkg::OPC_W-1:0] OPC_UNUSED_B = 3'd7;

  typedef struct {
    logic [dlp_pkg::OPC_W-1:0]    opc;
    logic [dlp_pkg::ID_W-1:0]     id;
    logic [dlp_pkg::HANDLE_W-1:0] handle;
    logic [dlp_pkg::COUNT_W-1:0]  count;
    int unsigned                  gap;
    bit                           drain;
  } pool_req_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [dlp_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
  logic [dlp_pkg::OPC_W-1:0]    s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [dlp_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic [dlp_pkg::STAT_W-1:0]   m_axis_tuser;
  logic                         m_axis_tlast;

  dedup_lifo_item_pool dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the pool.
  logic [dlp_pkg::ID_W-1:0]     slot_id_mem     [POOL_SLOTS];
  logic [dlp_pkg::HANDLE_W-1:0] slot_handle_mem [POOL_SLOTS];
  bit                           slot_is_live    [POOL_SLOTS];
  int                           slots_filled = 0;
  int                           live_now = 0;

  pool_req_t     req_queue[$];
  dlp_pkg::res_t pending_results[$];
  pool_req_t     cur_req;
  dlp_pkg::res_t want_res;
  bit            have_req = 1'b0;
  bit            quick_phase = 1'b0;
  int            hold_left = 0;
  int            stall_left = 0;
  int            sent_count = 0;
  int            taken_count = 0;
  int            result_count = 0;
  int            result_mark = 0;
  int            quiet_cycles = 0;
  int            error_count = 0;
  int            dup_refused = 0;
  int            full_refused = 0;

  function automatic int live_slot_of(input logic [dlp_pkg::ID_W-1:0] id);
    for (int i = 0; i < slots_filled; i++) begin
      if (slot_is_live[i] && slot_id_mem[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int newest_live_slot();
    for (int i = slots_filled - 1; i >= 0; i--) begin
      if (slot_is_live[i]) return i;
    end
    return -1;
  endfunction

  // Applies one accepted operation to the shadow pool and queues its results.
  task automatic predict_pool_op(input logic [dlp_pkg::OPC_W-1:0] opc,
                                 input logic [dlp_pkg::ID_W-1:0] id,
                                 input logic [dlp_pkg::HANDLE_W-1:0] hdl,
                                 input logic [dlp_pkg::COUNT_W-1:0] cnt);
    int            slot;
    int            want;
    dlp_pkg::res_t r;
    dlp_pkg::res_t batch[$];
    r = '0;
    r.last = 1'b1;
    case (opc)
      dlp_pkg::OP_PUSH: begin
        if (live_slot_of(id) >= 0) begin
          r.status = dlp_pkg::ST_DUP;
          dup_refused++;
        end else if (slots_filled >= POOL_SLOTS) begin
          r.status = dlp_pkg::ST_FULL;
          full_refused++;
        end else begin
          slot_id_mem[slots_filled]     = id;
          slot_handle_mem[slots_filled] = hdl;
          slot_is_live[slots_filled]    = 1'b1;
          slots_filled++;
          live_now++;
          r.status = dlp_pkg::ST_DONE;
        end
        r.live_count = dlp_pkg::COUNT_W'(live_now);
        pending_results.push_back(r);
      end
      dlp_pkg::OP_POP: begin
        slot = newest_live_slot();
        if (slot < 0) begin
          r.status = dlp_pkg::ST_NONE;
        end else begin
          slot_is_live[slot] = 1'b0;
          live_now--;
          r.status = dlp_pkg::ST_DONE;
          r.id     = slot_id_mem[slot];
          r.handle = slot_handle_mem[slot];
        end
        r.live_count = dlp_pkg::COUNT_W'(live_now);
        pending_results.push_back(r);
      end
      dlp_pkg::OP_FETCH: begin
        // A count of zero still takes one item.
        want = (cnt == '0) ? 1 : int'(cnt);
        slot = newest_live_slot();
        while (batch.size() < want && slot >= 0) begin
          slot_is_live[slot] = 1'b0;
          live_now--;
          r.status = dlp_pkg::ST_DONE;
          r.id     = slot_id_mem[slot];
          r.handle = slot_handle_mem[slot];
          batch.push_back(r);
          slot = newest_live_slot();
        end
        if (batch.size() == 0) begin
          r.status     = dlp_pkg::ST_NONE;
          r.live_count = dlp_pkg::COUNT_W'(live_now);
          pending_results.push_back(r);
        end else begin
          // Every result of a fetch reports the count after the whole fetch.
          foreach (batch[i]) begin
            batch[i].live_count = dlp_pkg::COUNT_W'(live_now);
            batch[i].last       = (i == batch.size() - 1);
            pending_results.push_back(batch[i]);
          end
        end
      end
      dlp_pkg::OP_REMOVE: begin
        slot = live_slot_of(id);
        if (slot < 0) begin
          r.status = dlp_pkg::ST_NONE;
        end else begin
          slot_is_live[slot] = 1'b0;
          live_now--;
          r.status = dlp_pkg::ST_DONE;
        end
        r.live_count = dlp_pkg::COUNT_W'(live_now);
        pending_results.push_back(r);
      end
      dlp_pkg::OP_QUERY: begin
        r.status     = dlp_pkg::ST_DONE;
        r.present    = (live_slot_of(id) >= 0);
        r.live_count = dlp_pkg::COUNT_W'(live_now);
        pending_results.push_back(r);
      end
      dlp_pkg::OP_CLEAR: begin
        foreach (slot_is_live[i]) slot_is_live[i] = 1'b0;
        slots_filled = 0;
        live_now     = 0;
        r.status     = dlp_pkg::ST_DONE;
        pending_results.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic queue_op(input logic [dlp_pkg::OPC_W-1:0] opc,
                          input logic [dlp_pkg::ID_W-1:0] id,
                          input logic [dlp_pkg::HANDLE_W-1:0] hdl,
                          input logic [dlp_pkg::COUNT_W-1:0] cnt,
                          input bit drain);
    pool_req_t q;
    q.opc    = opc;
    q.id     = id;
    q.handle = hdl;
    q.count  = cnt;
    q.gap    = quick_phase ? 0 : $urandom_range(0, 4);
    q.drain  = drain;
    req_queue.push_back(q);
  endtask

  // Sender: waits out each request's gap, and holds a draining request back
  // until every result so far has come out.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && sent_count != taken_count)) begin
      if (!have_req && req_queue.size() > 0) begin
        cur_req   = req_queue.pop_front();
        have_req  = 1'b1;
        hold_left = cur_req.gap;
      end
      if (have_req && hold_left == 0 && !(cur_req.drain && pending_results.size() > 0)) begin
        s_axis_tdata  <= {1'b0, cur_req.count, cur_req.handle, cur_req.id};
        s_axis_tuser  <= cur_req.opc;
        s_axis_tvalid <= 1'b1;
        sent_count++;
        have_req = 1'b0;
      end else begin
        if (hold_left > 0) hold_left--;
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls before each result, except in stretches of full speed.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_count != result_mark) begin
        result_mark = result_count;
        stall_left  = ((result_count / 48) % 3 == 2) ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checking, prediction of accepted operations, and the idle counter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: status %0d id 0x%0h", m_axis_tuser,
                 m_axis_tdata[64:1]);
          error_count++;
        end else begin
          want_res = pending_results.pop_front();
          check_field("status", 64'(want_res.status), 64'(m_axis_tuser));
          check_field("is_present", 64'(want_res.present), 64'(m_axis_tdata[0]));
          check_field("out_id", want_res.id, m_axis_tdata[64:1]);
          check_field("out_handle", 64'(want_res.handle), 64'(m_axis_tdata[96:65]));
          check_field("live_count", 64'(want_res.live_count), 64'(m_axis_tdata[103:97]));
          check_field("last", 64'(want_res.last), 64'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken_count++;
        predict_pool_op(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[95:64],
                        s_axis_tdata[102:96]);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [dlp_pkg::ID_W-1:0] round_ids[$];
    logic [dlp_pkg::ID_W-1:0] fresh;
    logic [dlp_pkg::ID_W-1:0] pick;
    int                       total_reqs;
    int                       random_ops;
    int                       round;
    int                       round_len;
    int                       dice;

    // Directed: empty pool, extreme ids and handles, duplicates, zero and
    // oversized fetch counts, unused opcodes and clear.
    queue_op(dlp_pkg::OP_POP, '0, '0, 7'd1, 1'b1);
    queue_op(dlp_pkg::OP_FETCH, '1, '1, 7'd0, 1'b0);
    queue_op(dlp_pkg::OP_QUERY, '0, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_REMOVE, '1, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_PUSH, '0, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_PUSH, '1, '1, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_PUSH, '0, 32'h1234_5678, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_QUERY, '1, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_FETCH, '0, '0, 7'd0, 1'b0);
    queue_op(dlp_pkg::OP_PUSH, '1, 32'h5a5a_a5a5, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_REMOVE, '0, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_REMOVE, '0, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_POP, '0, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_POP, '0, '0, 7'd1, 1'b0);
    for (int i = 0; i < 3; i++) begin
      queue_op(dlp_pkg::OP_PUSH, {$urandom, $urandom}, $urandom, '1, 1'b0);
    end
    queue_op(dlp_pkg::OP_FETCH, '0, '0, 7'd127, 1'b0);
    queue_op(OPC_UNUSED_A, {$urandom, $urandom}, $urandom, 7'd5, 1'b0);
    queue_op(OPC_UNUSED_B, '1, '1, '1, 1'b0);
    queue_op(dlp_pkg::OP_QUERY, {$urandom, $urandom}, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_CLEAR, '1, '1, '1, 1'b0);

    // Fill the pool past capacity, with duplicate pushes and queries mixed in,
    // then drain it with one fetch of as many items as the pool has slots.
    queue_op(dlp_pkg::OP_CLEAR, '0, '0, 7'd1, 1'b1);
    random_ops = 1;
    for (int i = 0; i < 72; i++) begin
      fresh = {$urandom, $urandom};
      round_ids.push_back(fresh);
      queue_op(dlp_pkg::OP_PUSH, fresh, $urandom, 7'($urandom), 1'b0);
      random_ops++;
      if (i % 8 == 7) begin
        queue_op(dlp_pkg::OP_PUSH, round_ids[$urandom_range(0, round_ids.size() - 1)],
                 $urandom, 7'd1, 1'b0);
        queue_op(dlp_pkg::OP_QUERY, round_ids[$urandom_range(0, round_ids.size() - 1)],
                 '0, 7'd1, 1'b0);
        random_ops += 2;
      end
    end
    queue_op(dlp_pkg::OP_FETCH, '0, '0, 7'd64, 1'b0);
    queue_op(dlp_pkg::OP_POP, '0, '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_QUERY, round_ids[0], '0, 7'd1, 1'b0);
    queue_op(dlp_pkg::OP_FETCH, '0, '0, 7'd1, 1'b0);
    random_ops += 4;

    // Mixed rounds, each opened by a clear that waits for the pool to settle.
    round = 0;
    while (random_ops < 150) begin
      round++;
      quick_phase = (round % 3 == 2);
      round_ids.delete();
      queue_op(dlp_pkg::OP_CLEAR, '0, '0, 7'd1, 1'b1);
      random_ops++;
      round_len = $urandom_range(12, 28);
      for (int i = 0; i < round_len; i++) begin
        dice  = $urandom_range(0, 99);
        fresh = {$urandom, $urandom};
        pick  = (round_ids.size() > 0 && $urandom_range(0, 9) < 7) ?
                round_ids[$urandom_range(0, round_ids.size() - 1)] : fresh;
        if (dice < 40) begin
          if ($urandom_range(0, 2) != 0) pick = fresh;
          round_ids.push_back(pick);
          queue_op(dlp_pkg::OP_PUSH, pick, $urandom, 7'($urandom), 1'b0);
        end else if (dice < 52) begin
          queue_op(dlp_pkg::OP_POP, pick, $urandom, 7'($urandom), 1'b0);
        end else if (dice < 62) begin
          queue_op(dlp_pkg::OP_FETCH, pick, $urandom,
                   ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
                                                  7'($urandom_range(1, 5)), 1'b0);
        end else if (dice < 76) begin
          queue_op(dlp_pkg::OP_REMOVE, pick, $urandom, 7'($urandom), 1'b0);
        end else if (dice < 92) begin
          queue_op(dlp_pkg::OP_QUERY, pick, $urandom, 7'($urandom), 1'b0);
        end else if (dice < 96) begin
          round_ids.delete();
          queue_op(dlp_pkg::OP_CLEAR, fresh, $urandom, 7'($urandom), 1'b0);
        end else begin
          queue_op(($urandom_range(0, 1) == 0) ? OPC_UNUSED_A : OPC_UNUSED_B, fresh,
                   $urandom, 7'($urandom), 1'b0);
          random_ops--;
        end
        random_ops++;
      end
    end
    total_reqs = req_queue.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_count < total_reqs || pending_results.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d pool operations and checked %0d results.", taken_count, result_count);
    $display("Pushes refused: %0d as duplicates, %0d with every slot used.", dup_refused,
             full_refused);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
